[design/apf_predictive_current_select_top_assert.svh]
// Assertion macros for the predictive current select block.
`ifndef APF_PREDICTIVE_CURRENT_SELECT_TOP_ASSERT_SVH
`define APF_PREDICTIVE_CURRENT_SELECT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define APF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define APF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define APF_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define APF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[design/apf_pcs_pkg.sv]
// Package: constants, state types and lane command word for the current select block.
`timescale 1ns / 1ps
`default_nettype none
package apf_pcs_pkg;

    // Q1.30 constants
    localparam logic signed [31:0] K_SQRT_2_3  = 32'sd876706528;
    localparam logic signed [31:0] K_INV_SQRT2 = 32'sd759250125;
    localparam logic signed [31:0] K_SQRT3_2   = 32'sd929887697;

    // quotient bits produced by the divider (quotient stays below 2^26)
    localparam int DIV_QBITS = 28;
    localparam int DIV_CNT_W = $clog2(DIV_QBITS);

    localparam int LVL_W = 2;

    typedef enum logic [2:0] {
        CFG_DECAY   = 3'd0,
        CFG_GAIN    = 3'd1,
        CFG_DC_LINK = 3'd2,
        CFG_LEVEL0  = 3'd3,
        CFG_LEVEL1  = 3'd4,
        CFG_LEVEL2  = 3'd5,
        CFG_LEVEL3  = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLARKE,
        S_POWER,
        S_SUM,
        S_DIV_GO,
        S_DIV_WAIT,
        S_REF1,
        S_REF2,
        S_LEVELS,
        S_DRAIN,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        D_IDLE,
        D_MUL,
        D_ADD,
        D_RUN,
        D_FIN
    } t_div_state;

    // one level candidate broadcast to the phase lanes
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [LVL_W-1:0]   idx;
        logic signed [26:0] u;
    } t_lvl_cmd;

endpackage
`default_nettype wire

[design/apf_pcs_ifs.sv]
// Channel interfaces: sample input, result output and register write.
`timescale 1ns / 1ps
`default_nettype none
interface apf_pcs_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] grid_voltage_a;
    logic signed [23:0] grid_voltage_b;
    logic signed [23:0] grid_voltage_c;
    logic signed [23:0] load_current_a;
    logic signed [23:0] load_current_b;
    logic signed [23:0] load_current_c;
    logic signed [23:0] filter_current_a;
    logic signed [23:0] filter_current_b;
    logic signed [23:0] filter_current_c;
    modport source (output valid, grid_voltage_a, grid_voltage_b, grid_voltage_c,
                    load_current_a, load_current_b, load_current_c,
                    filter_current_a, filter_current_b, filter_current_c,
                    input ready);
    modport sink (input valid, grid_voltage_a, grid_voltage_b, grid_voltage_c,
                  load_current_a, load_current_b, load_current_c,
                  filter_current_a, filter_current_b, filter_current_c,
                  output ready);
endinterface

interface apf_pcs_out_if;
    logic               valid;
    logic               ready;
    logic [5:0]         switch_bits;
    logic [1:0]         best_level_a;
    logic [1:0]         best_level_b;
    logic [1:0]         best_level_c;
    logic signed [23:0] ref_current_a;
    logic signed [23:0] ref_current_b;
    logic signed [23:0] ref_current_c;
    logic signed [31:0] load_active_power;
    logic signed [31:0] load_reactive_power;
    modport source (output valid, switch_bits, best_level_a, best_level_b, best_level_c,
                    ref_current_a, ref_current_b, ref_current_c,
                    load_active_power, load_reactive_power, input ready);
    modport sink (input valid, switch_bits, best_level_a, best_level_b, best_level_c,
                  ref_current_a, ref_current_b, ref_current_c,
                  load_active_power, load_reactive_power, output ready);
endinterface

interface apf_pcs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[design/apf_pcs_div.sv]
// Multiply-divide unit: round(|v|*|p|/d) with sign, restoring, one quotient bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module apf_pcs_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [24:0] i_v,
    input  logic signed [50:0] i_p,
    input  logic [49:0]        i_d,
    output logic signed [29:0] o_q,
    output logic               o_done
);
    localparam int QB = apf_pcs_pkg::DIV_QBITS;
    localparam int CW = apf_pcs_pkg::DIV_CNT_W;

    apf_pcs_pkg::t_div_state r_state, n_state;

    logic [24:0]        r_mv;
    logic [50:0]        r_mp;
    logic               r_neg;
    logic [49:0]        r_d;
    logic [50:0]        r_lo;
    logic [49:0]        r_hi;
    logic [49:0]        r_rem;
    logic [QB-1:0]      r_n;
    logic [QB-1:0]      r_q;
    logic [CW-1:0]      r_cnt;
    logic signed [29:0] r_out;
    logic               r_done;

    logic [76:0] w_num;
    logic [50:0] w_trial;
    logic        w_fit;
    logic        w_up;
    logic [28:0] w_qr;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= apf_pcs_pkg::D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            apf_pcs_pkg::D_IDLE: if (i_start) n_state = apf_pcs_pkg::D_MUL;
            apf_pcs_pkg::D_MUL:  n_state = apf_pcs_pkg::D_ADD;
            apf_pcs_pkg::D_ADD:  n_state = apf_pcs_pkg::D_RUN;
            apf_pcs_pkg::D_RUN:  if (r_cnt == CW'(QB - 1)) n_state = apf_pcs_pkg::D_FIN;
            apf_pcs_pkg::D_FIN:  n_state = apf_pcs_pkg::D_IDLE;
            default:             n_state = apf_pcs_pkg::D_IDLE;
        endcase
    end

    // datapath terms
    assign w_num   = 77'(r_lo) + (77'(r_hi) << 26);
    assign w_trial = {r_rem, r_n[QB-1]};
    assign w_fit   = (w_trial >= {1'b0, r_d});
    assign w_up    = ({r_rem, 1'b0} >= {1'b0, r_d});
    assign w_qr    = 29'(r_q) + (w_up ? 29'd1 : 29'd0);

    // operands, partial products and long division
    always_ff @(posedge i_clk) begin
        case (r_state)
            apf_pcs_pkg::D_IDLE: begin
                r_mv  <= i_v[24] ? 25'(-i_v) : 25'(i_v);
                r_mp  <= i_p[50] ? 51'(-i_p) : 51'(i_p);
                r_neg <= i_v[24] ^ i_p[50];
                r_d   <= i_d;
            end
            apf_pcs_pkg::D_MUL: begin
                r_lo <= 51'(r_mv * r_mp[25:0]);
                r_hi <= 50'(r_mv * r_mp[50:26]);
            end
            apf_pcs_pkg::D_ADD: begin
                r_rem <= 50'(w_num >> QB);
                r_n   <= w_num[QB-1:0];
                r_q   <= '0;
                r_cnt <= '0;
            end
            apf_pcs_pkg::D_RUN: begin
                r_rem <= w_fit ? 50'(w_trial - {1'b0, r_d}) : 50'(w_trial);
                r_n   <= r_n << 1;
                r_q   <= {r_q[QB-2:0], w_fit};
                r_cnt <= r_cnt + 1'b1;
            end
            apf_pcs_pkg::D_FIN: begin
                r_out <= r_neg ? -$signed(30'(w_qr)) : $signed(30'(w_qr));
            end
            default: ;
        endcase
    end

    // completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == apf_pcs_pkg::D_FIN);
        end
    end

    assign o_q    = r_out;
    assign o_done = r_done;
endmodule
`default_nettype wire

[design/apf_pcs_lane.sv]
// Phase lane: predicts the next filter current per level and keeps the least error.
`timescale 1ns / 1ps
`default_nettype none
module apf_pcs_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic signed [23:0]          i_v,
    input  logic signed [23:0]          i_fi,
    input  logic signed [23:0]          i_ref,
    input  logic [30:0]                 i_decay,
    input  logic [31:0]                 i_gain,
    input  apf_pcs_pkg::t_lvl_cmd       i_cmd,
    output logic [apf_pcs_pkg::LVL_W-1:0] o_best,
    output logic                        o_done
);
    localparam int LW = apf_pcs_pkg::LVL_W;

    logic signed [25:0] r_dec;
    logic signed [28:0] r_b;
    logic               r_a_valid;
    logic               r_a_last;
    logic [LW-1:0]      r_a_idx;
    logic [LW-1:0]      r_best;
    logic [30:0]        r_best_e;
    logic               r_done;

    logic signed [55:0] w_dp;
    logic signed [27:0] w_diff;
    logic signed [60:0] w_gp;
    logic signed [29:0] w_pred;
    logic signed [30:0] w_e;
    logic [30:0]        w_mag;
    logic               w_take;

    // decay term, from stable operands
    assign w_dp = 56'(i_fi) * 56'($signed({1'b0, i_decay}));
    always_ff @(posedge i_clk) begin
        r_dec <= 26'((w_dp + (56'sd1 <<< 29)) >>> 30);
    end

    // stage A: voltage term for the candidate level
    assign w_diff = 28'(i_v) - 28'(i_cmd.u);
    assign w_gp   = 61'(w_diff) * 61'($signed({1'b0, i_gain}));
    always_ff @(posedge i_clk) begin
        r_b     <= 29'((w_gp + (61'sd1 <<< 31)) >>> 32);
        r_a_last <= i_cmd.last;
        r_a_idx <= i_cmd.idx;
    end

    // stage B: error magnitude and running best; ties keep the lower level
    assign w_pred = 30'(r_dec) + 30'(r_b);
    assign w_e    = 31'(i_ref) - 31'(w_pred);
    assign w_mag  = w_e[30] ? 31'(-w_e) : 31'(w_e);
    assign w_take = r_a_valid && ((r_a_idx == '0) || (w_mag < r_best_e));
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_best   <= r_a_idx;
            r_best_e <= w_mag;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_a_valid <= i_cmd.valid;
            r_done    <= r_a_valid && r_a_last;
        end
    end

    assign o_best = r_best;
    assign o_done = r_done;
endmodule
`default_nettype wire

[design/apf_predictive_current_select_top.sv]
// Top level: Clarke and p-q front end, reference dividers, phase lanes, result register.
//
//  channel    dir  port      payload
//  sample     in   i_sample  grid voltages, load currents, filter currents (24 b each)
//  result     out  o_result  switch bits, best levels, references, load p and q
//  register   in   i_cfg     3 b index, 32 b data
//
// One sample at a time; most of the work is done by the two 28-step restoring
// dividers, one for each of the alpha and beta references.
// The next sample is taken as soon as the result sits in the output register.
// Reset (i_rst_n low, synchronous) clears control state and loads register defaults.
// A stalled result holds the output register; the block waits in its last state.
`timescale 1ns / 1ps
`default_nettype none
module apf_predictive_current_select_top #(
    parameter int NUM_LEVELS = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    apf_pcs_in_if.sink     i_sample,
    apf_pcs_out_if.source  o_result,
    apf_pcs_cfg_if.sink    i_cfg
);
    localparam int LW = apf_pcs_pkg::LVL_W;

    function automatic logic signed [23:0] sat24(input logic signed [31:0] x);
        if (x > 32'sd8388607) return 24'sd8388607;
        else if (x < -32'sd8388608) return -24'sd8388608;
        else return 24'(x);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [42:0] x);
        if (x > 43'sd2147483647) return 32'sd2147483647;
        else if (x < -43'sd2147483648) return -32'sd2147483648;
        else return 32'(x);
    endfunction

    apf_pcs_pkg::t_state r_state, n_state;

    // configuration registers
    logic [30:0]        r_decay;
    logic [31:0]        r_gain;
    logic [23:0]        r_dc;
    logic signed [15:0] r_lvl [4];

    // sample and intermediate registers
    logic signed [23:0] r_v  [3];
    logic signed [23:0] r_il [3];
    logic signed [23:0] r_fi [3];
    logic signed [24:0] r_va, r_vb, r_ia, r_ib;
    logic signed [49:0] r_m_pa, r_m_pb, r_m_qa, r_m_qb, r_m_da, r_m_db;
    logic signed [50:0] r_p, r_q;
    logic [49:0]        r_d;
    logic signed [23:0] r_ref [3];
    logic signed [30:0] r_mb, r_mc;
    logic [LW-1:0]      r_iss;
    apf_pcs_pkg::t_lvl_cmd r_cmd;

    // output register
    logic               r_out_valid;
    logic [LW-1:0]      r_o_best [3];
    logic signed [23:0] r_o_ref  [3];
    logic signed [31:0] r_o_p, r_o_q;

    logic w_in_ready, w_div_start, w_load_out, w_accept;
    logic signed [29:0] w_ica, w_icb;
    logic w_div_done_a, w_div_done_b;
    logic [LW-1:0] w_best [3];
    logic [2:0]    w_lane_done;

    // Clarke terms
    logic signed [26:0] w_vs_a, w_is_a;
    logic signed [24:0] w_vs_b, w_is_b;
    logic signed [57:0] w_pva, w_pia;
    logic signed [55:0] w_pvb, w_pib;
    // reference terms
    logic signed [59:0] w_k0;
    logic signed [60:0] w_k3, w_ha;
    logic signed [61:0] w_kb, w_kc;
    logic signed [40:0] w_up;

    // register writes
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay <= 31'd1073741824;
            r_gain  <= '0;
            r_dc    <= '0;
            r_lvl   <= '{default: '0};
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                apf_pcs_pkg::CFG_DECAY:   r_decay <= i_cfg.data[30:0];
                apf_pcs_pkg::CFG_GAIN:    r_gain  <= i_cfg.data;
                apf_pcs_pkg::CFG_DC_LINK: r_dc    <= i_cfg.data[23:0];
                apf_pcs_pkg::CFG_LEVEL0:  r_lvl[0] <= $signed(i_cfg.data[15:0]);
                apf_pcs_pkg::CFG_LEVEL1:  r_lvl[1] <= $signed(i_cfg.data[15:0]);
                apf_pcs_pkg::CFG_LEVEL2:  r_lvl[2] <= $signed(i_cfg.data[15:0]);
                apf_pcs_pkg::CFG_LEVEL3:  r_lvl[3] <= $signed(i_cfg.data[15:0]);
                default: ;
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= apf_pcs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        w_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        unique case (r_state)
            apf_pcs_pkg::S_IDLE: begin
                w_in_ready = 1'b1;
                if (i_sample.valid) n_state = apf_pcs_pkg::S_CLARKE;
            end
            apf_pcs_pkg::S_CLARKE: n_state = apf_pcs_pkg::S_POWER;
            apf_pcs_pkg::S_POWER:  n_state = apf_pcs_pkg::S_SUM;
            apf_pcs_pkg::S_SUM:    n_state = apf_pcs_pkg::S_DIV_GO;
            apf_pcs_pkg::S_DIV_GO: begin
                w_div_start = 1'b1;
                n_state     = apf_pcs_pkg::S_DIV_WAIT;
            end
            apf_pcs_pkg::S_DIV_WAIT: begin
                if (w_div_done_a && w_div_done_b) n_state = apf_pcs_pkg::S_REF1;
            end
            apf_pcs_pkg::S_REF1:   n_state = apf_pcs_pkg::S_REF2;
            apf_pcs_pkg::S_REF2:   n_state = apf_pcs_pkg::S_LEVELS;
            apf_pcs_pkg::S_LEVELS: begin
                if (r_iss == LW'(NUM_LEVELS - 1)) n_state = apf_pcs_pkg::S_DRAIN;
            end
            apf_pcs_pkg::S_DRAIN: if (&w_lane_done) n_state = apf_pcs_pkg::S_OUT;
            apf_pcs_pkg::S_OUT: begin
                if (!r_out_valid || o_result.ready) begin
                    w_load_out = 1'b1;
                    n_state    = apf_pcs_pkg::S_IDLE;
                end
            end
            default: n_state = apf_pcs_pkg::S_IDLE;
        endcase
    end

    assign i_sample.ready = w_in_ready;
    assign w_accept       = i_sample.valid && w_in_ready;

    // sample capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_v[0]  <= i_sample.grid_voltage_a;
            r_v[1]  <= i_sample.grid_voltage_b;
            r_v[2]  <= i_sample.grid_voltage_c;
            r_il[0] <= i_sample.load_current_a;
            r_il[1] <= i_sample.load_current_b;
            r_il[2] <= i_sample.load_current_c;
            r_fi[0] <= i_sample.filter_current_a;
            r_fi[1] <= i_sample.filter_current_b;
            r_fi[2] <= i_sample.filter_current_c;
        end
    end

    // Clarke transform, power invariant
    assign w_vs_a = (27'(r_v[0]) <<< 1) - 27'(r_v[1]) - 27'(r_v[2]);
    assign w_is_a = (27'(r_il[0]) <<< 1) - 27'(r_il[1]) - 27'(r_il[2]);
    assign w_vs_b = 25'(r_v[1]) - 25'(r_v[2]);
    assign w_is_b = 25'(r_il[1]) - 25'(r_il[2]);
    assign w_pva  = 58'(w_vs_a) * 58'(apf_pcs_pkg::K_SQRT_2_3);
    assign w_pia  = 58'(w_is_a) * 58'(apf_pcs_pkg::K_SQRT_2_3);
    assign w_pvb  = 56'(w_vs_b) * 56'(apf_pcs_pkg::K_INV_SQRT2);
    assign w_pib  = 56'(w_is_b) * 56'(apf_pcs_pkg::K_INV_SQRT2);

    always_ff @(posedge i_clk) begin
        if (r_state == apf_pcs_pkg::S_CLARKE) begin
            r_va <= 25'((w_pva + (58'sd1 <<< 30)) >>> 31);
            r_ia <= 25'((w_pia + (58'sd1 <<< 30)) >>> 31);
            r_vb <= 25'((w_pvb + (56'sd1 <<< 29)) >>> 30);
            r_ib <= 25'((w_pib + (56'sd1 <<< 29)) >>> 30);
        end
    end

    // p-q products, then sums and the denominator
    always_ff @(posedge i_clk) begin
        if (r_state == apf_pcs_pkg::S_POWER) begin
            r_m_pa <= 50'(r_va) * 50'(r_ia);
            r_m_pb <= 50'(r_vb) * 50'(r_ib);
            r_m_qa <= 50'(r_vb) * 50'(r_ia);
            r_m_qb <= 50'(r_va) * 50'(r_ib);
            r_m_da <= 50'(r_va) * 50'(r_va);
            r_m_db <= 50'(r_vb) * 50'(r_vb);
        end
        if (r_state == apf_pcs_pkg::S_SUM) begin
            r_p <= 51'(r_m_pa) + 51'(r_m_pb);
            r_q <= 51'(r_m_qa) - 51'(r_m_qb);
            r_d <= $unsigned(r_m_da) + $unsigned(r_m_db) + 50'd1;
        end
    end

    // alpha and beta compensation currents
    apf_pcs_div u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_v     (r_va),
        .i_p     (r_p),
        .i_d     (r_d),
        .o_q     (w_ica),
        .o_done  (w_div_done_a)
    );

    apf_pcs_div u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_v     (r_vb),
        .i_p     (r_p),
        .i_d     (r_d),
        .o_q     (w_icb),
        .o_done  (w_div_done_b)
    );

    // inverse Clarke to phase references
    assign w_k0 = 60'(w_ica) * 60'(apf_pcs_pkg::K_SQRT_2_3);
    assign w_k3 = 61'(w_icb) * 61'(apf_pcs_pkg::K_SQRT3_2);
    assign w_ha = 61'(w_ica) <<< 29;
    assign w_kb = 62'(r_mb) * 62'(apf_pcs_pkg::K_SQRT_2_3);
    assign w_kc = 62'(r_mc) * 62'(apf_pcs_pkg::K_SQRT_2_3);

    always_ff @(posedge i_clk) begin
        if (r_state == apf_pcs_pkg::S_REF1) begin
            r_ref[0] <= sat24(32'((w_k0 + (60'sd1 <<< 29)) >>> 30));
            r_mb     <= 31'((w_k3 - w_ha + (61'sd1 <<< 29)) >>> 30);
            r_mc     <= 31'((-w_k3 - w_ha + (61'sd1 <<< 29)) >>> 30);
        end
        if (r_state == apf_pcs_pkg::S_REF2) begin
            r_ref[1] <= sat24(32'((w_kb + (62'sd1 <<< 29)) >>> 30));
            r_ref[2] <= sat24(32'((w_kc + (62'sd1 <<< 29)) >>> 30));
        end
    end

    // level candidates, one a cycle
    assign w_up = 41'(r_lvl[r_iss]) * 41'($signed({1'b0, r_dc}));
    always_ff @(posedge i_clk) begin
        r_cmd.u    <= 27'((w_up + (41'sd1 <<< 13)) >>> 14);
        r_cmd.idx  <= r_iss;
        r_cmd.last <= (r_iss == LW'(NUM_LEVELS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss       <= '0;
            r_cmd.valid <= 1'b0;
        end else begin
            r_cmd.valid <= (r_state == apf_pcs_pkg::S_LEVELS);
            if (r_state == apf_pcs_pkg::S_LEVELS) r_iss <= r_iss + 1'b1;
            else r_iss <= '0;
        end
    end

    // phase lanes
    for (genvar k = 0; k < 3; k++) begin : g_lane
        apf_pcs_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_v     (r_v[k]),
            .i_fi    (r_fi[k]),
            .i_ref   (r_ref[k]),
            .i_decay (r_decay),
            .i_gain  (r_gain),
            .i_cmd   (r_cmd),
            .o_best  (w_best[k]),
            .o_done  (w_lane_done[k])
        );
    end

    // merge and output register
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_best <= w_best;
            r_o_ref  <= r_ref;
            r_o_p    <= sat32(43'((r_p + 51'sd128) >>> 8));
            r_o_q    <= sat32(43'((r_q + 51'sd128) >>> 8));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_result.valid               = r_out_valid;
    assign o_result.switch_bits         = {r_o_best[0], r_o_best[1], r_o_best[2]};
    assign o_result.best_level_a        = r_o_best[0];
    assign o_result.best_level_b        = r_o_best[1];
    assign o_result.best_level_c        = r_o_best[2];
    assign o_result.ref_current_a       = r_o_ref[0];
    assign o_result.ref_current_b       = r_o_ref[1];
    assign o_result.ref_current_c       = r_o_ref[2];
    assign o_result.load_active_power   = r_o_p;
    assign o_result.load_reactive_power = r_o_q;

    // checks
`include "apf_predictive_current_select_top_assert.svh"
    `APF_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_accept, r_state == apf_pcs_pkg::S_CLARKE)
    `APF_ASSERT_NOW(a_div_in_step, i_clk, i_rst_n, w_div_done_a, w_div_done_b)
    `APF_ASSERT_NOW(a_lanes_drain, i_clk, i_rst_n, w_lane_done[0], r_state == apf_pcs_pkg::S_DRAIN)
    `APF_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, w_load_out, o_result.valid)
endmodule
`default_nettype wire
